// ===== design/window_convolution_2d_top_defines.svh =====
// Assertion macros for the windowed convolution block.
// Used by window_convolution_2d_top; no other dependencies.
`ifndef WINDOW_CONVOLUTION_2D_TOP_DEFINES_SVH
`define WINDOW_CONVOLUTION_2D_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WCV_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);
`define WCV_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define WCV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WCV_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define WCV_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define WCV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== design/wcv_pkg.sv =====
// Shared constants and types of the windowed convolution block.
// No dependencies.
package wcv_pkg;

    localparam int DEF_KERNEL_SIZE = 3;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_COEF_BITS   = 12;

    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_BUS_W  = NUM_CH * PIX_W;
    localparam int SUM_W      = 25;
    localparam int SUM_LIMIT  = 13107200;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_DATA_W = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int GEOM_W     = 11;
    localparam int ROW_W      = 11;
    localparam int COEF_SPAN  = 64;

    localparam int FIFO_DEPTH  = 8;
    localparam int PIPE_STAGES = 5;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR     = 3'd7;

    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic shift;
        logic keep;
    } t_cell_ctl;

    typedef struct packed {
        logic has_res;
        logic frame_end;
    } t_tag;

    typedef struct packed {
        logic                    frame_end;
        logic signed [SUM_W-1:0] sum2;
        logic signed [SUM_W-1:0] sum1;
        logic signed [SUM_W-1:0] sum0;
    } t_res;

endpackage

// ===== design/wcv_ram.sv =====
// Generic simple dual-port RAM, registered read, read-first on collision.
// No dependencies.
module wcv_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/wcv_cell.sv =====
// One window tap: holds a pixel, passes it to its neighbor, weights it.
// Depends on wcv_pkg.
module wcv_cell #(
    parameter int COEF_BITS = wcv_pkg::DEF_COEF_BITS
) (
    input  logic                                        i_clk,
    input  wcv_pkg::t_cell_ctl                          i_ctl,
    input  logic [wcv_pkg::PIX_BUS_W-1:0]               i_pix,
    input  logic signed [COEF_BITS-1:0]                 i_coef,
    output logic [wcv_pkg::PIX_BUS_W-1:0]               o_pix,
    output logic signed [COEF_BITS+wcv_pkg::PIX_W-1:0] o_prod [wcv_pkg::NUM_CH]
);
    import wcv_pkg::*;

    localparam int PW = COEF_BITS + PIX_W;

    logic [PIX_BUS_W-1:0]    r_pix;
    logic signed [PW-1:0]    r_prod [NUM_CH];
    logic signed [PW:0]      w_full [NUM_CH];

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            w_full[ch] = i_coef * $signed({1'b0, r_pix[ch*PIX_W +: PIX_W]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_pix <= i_pix;
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            r_prod[ch] <= i_ctl.keep ? w_full[ch][PW-1:0] : '0;
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule

// ===== design/wcv_sum.sv =====
// Registered adder tree over the window products of one channel, with clamp.
// Depends on wcv_pkg.
module wcv_sum #(
    parameter int TAPS = 3,
    parameter int PW   = 20
) (
    input  logic                           i_clk,
    input  logic signed [PW-1:0]           i_prod [TAPS*TAPS],
    output logic signed [wcv_pkg::SUM_W-1:0] o_sum
);
    import wcv_pkg::*;

    localparam int NT = TAPS * TAPS;
    localparam int RW = PW + $clog2(TAPS);
    localparam int TW = PW + $clog2(NT);
    localparam int EW = (TW > SUM_W) ? TW : SUM_W;
    localparam logic signed [EW-1:0] LIM  = EW'(SUM_LIMIT);
    localparam logic signed [EW-1:0] NLIM = -LIM;

    logic signed [RW-1:0] w_row [TAPS];
    logic signed [RW-1:0] r_row [TAPS];
    logic signed [TW-1:0] w_total;
    logic signed [TW-1:0] r_total;
    logic signed [EW-1:0] w_ext;

    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            w_row[i] = '0;
            for (int j = 0; j < TAPS; j++) begin
                w_row[i] = w_row[i] + RW'(i_prod[i*TAPS+j]);
            end
        end
    end

    always_comb begin
        w_total = '0;
        for (int i = 0; i < TAPS; i++) begin
            w_total = w_total + TW'(r_row[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= w_row;
        r_total <= w_total;
    end

    assign w_ext = EW'(r_total);

    always_comb begin
        if (w_ext > LIM) begin
            o_sum = LIM[SUM_W-1:0];
        end else if (w_ext < NLIM) begin
            o_sum = NLIM[SUM_W-1:0];
        end else begin
            o_sum = w_ext[SUM_W-1:0];
        end
    end

endmodule

// ===== design/window_convolution_2d_top.sv =====
// Top level of the KxK zero-padded window convolution: line store, tap cells,
// adder trees and an output queue. Depends on wcv_pkg, wcv_ram, wcv_cell, wcv_sum.
// Throughput: one word per cycle while the queue has room. Results are registered
// in cells and adder trees; a window ends R*width+R words after its center pixel.
// Reset (synchronous): counters, queue pointers, valid bits and config; no sweep.
`include "window_convolution_2d_top_defines.svh"
module window_convolution_2d_top #(
    parameter int KERNEL_SIZE = wcv_pkg::DEF_KERNEL_SIZE,
    parameter int MAX_WIDTH   = wcv_pkg::DEF_MAX_WIDTH,
    parameter int COEF_BITS   = wcv_pkg::DEF_COEF_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [wcv_pkg::PIX_BUS_W-1:0]    s_axis_tdata,  // chan0, chan1, chan2
    input  logic                             s_axis_tuser,  // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [wcv_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // sum0, sum1, sum2, zero pad
    output logic                             m_axis_tlast,  // frame_end
    input  logic                             i_cfg_wr_en,
    input  logic [wcv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wcv_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wcv_pkg::*;

    localparam int RADIUS     = (KERNEL_SIZE - 1) / 2;
    localparam int TAPS       = 2 * RADIUS + 1;
    localparam int NT         = TAPS * TAPS;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int CW         = WW + 2;
    localparam int RSW        = ROW_W + 2;
    localparam int PW         = COEF_BITS + PIX_W;
    localparam int LB_W       = PIX_BUS_W * (TAPS - 1);
    localparam int LEAD_MAX   = RADIUS * MAX_WIDTH + RADIUS;
    localparam int FILL_W     = $clog2(LEAD_MAX + 1);
    localparam int WIDTH_RST  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int COEF_EXT_W = COEF_SPAN + COEF_BITS;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int INF_W      = $clog2(PIPE_STAGES + 1);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + PIPE_STAGES + 1);

    // configuration
    logic [CFG_DATA_W-1:0] r_coef [TAPS];
    logic [WW-1:0]         r_width;
    logic [ROW_W-1:0]      r_height;
    logic                  r_color;
    logic [WW-1:0]         w_new_width;
    logic [ROW_W-1:0]      w_new_height;
    logic                  w_geom_wr;

    // frame counters
    logic [ADDR_W-1:0] r_in_col,  n_in_col;
    logic [FILL_W-1:0] r_fill,    n_fill;
    logic [ADDR_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [FILL_W-1:0] w_lead;
    logic              w_started;
    logic              w_last_in_col;
    logic              w_last_out_col;
    logic              w_frame_end;
    logic              w_s_acc;
    logic [PIX_BUS_W-1:0] w_pix;

    // pipeline
    logic [PIPE_STAGES-1:0] r_vld;
    t_tag                   r_tag [PIPE_STAGES];
    logic [PIX_BUS_W-1:0]   r_a_pix;
    logic [ADDR_W-1:0]      r_a_col;
    logic [TAPS-1:0]        w_row_ok, w_col_ok;
    logic [TAPS-1:0]        r_a_row_ok, r_a_col_ok;
    logic [TAPS-1:0]        r_b_row_ok, r_b_col_ok;

    // line store
    logic [LB_W-1:0]      w_ram_q;
    logic [LB_W-1:0]      w_rd_word;
    logic [LB_W-1:0]      w_wr_word;
    logic                 r_fwd_hit;
    logic [LB_W-1:0]      r_fwd_word;
    logic [PIX_BUS_W-1:0] w_row_feed [TAPS];

    // window cells
    logic [PIX_BUS_W-1:0]  w_win [TAPS][TAPS];
    logic [COEF_EXT_W-1:0] w_coef_ext [TAPS];
    logic signed [PW-1:0]  w_cell_prod [NT][NUM_CH];
    logic signed [PW-1:0]  w_prod [NUM_CH][NT];
    logic signed [SUM_W-1:0] w_sum [NUM_CH];

    // output queue
    t_res             r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [INF_W-1:0] w_inflight;
    logic [OCC_W-1:0] w_occ;
    logic             w_push, w_pop;
    t_res             w_res, w_head;

    // ---------------- configuration ----------------
    always_comb begin
        if (i_cfg_data[GEOM_W-1:0] == '0) begin
            w_new_width = WW'(1);
        end else if (int'(i_cfg_data[GEOM_W-1:0]) > MAX_WIDTH) begin
            w_new_width = WW'(MAX_WIDTH);
        end else begin
            w_new_width = WW'(i_cfg_data[GEOM_W-1:0]);
        end
        if (i_cfg_data[GEOM_W-1:0] == '0) begin
            w_new_height = ROW_W'(1);
        end else begin
            w_new_height = i_cfg_data[ROW_W-1:0];
        end
    end

    assign w_geom_wr = i_cfg_wr_en && (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT);

    for (genvar gk = 0; gk < TAPS; gk++) begin : g_coef
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_coef[gk] <= '0;
            end else if (i_cfg_wr_en && i_cfg_index == REG_COEF_ROW0 + CFG_IDX_W'(gk)) begin
                r_coef[gk] <= i_cfg_data;
            end
        end
        assign w_coef_ext[gk] = COEF_EXT_W'(r_coef[gk]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(WIDTH_RST);
            r_height <= ROW_W'(HEIGHT_RESET);
            r_color  <= 1'b1;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_width <= w_new_width;
            end
            if (i_cfg_index == REG_HEIGHT) begin
                r_height <= w_new_height;
            end
            if (i_cfg_index == REG_COLOR) begin
                r_color <= i_cfg_data[0];
            end
        end
    end

    // ---------------- frame counters ----------------
    assign w_s_acc        = s_axis_tvalid && s_axis_tready;
    assign w_pix          = (s_axis_tuser == FUNC_FLUSH) ? '0 : s_axis_tdata;
    assign w_lead         = FILL_W'(RADIUS * int'(r_width) + RADIUS);
    assign w_started      = (r_fill == w_lead);
    assign w_last_in_col  = (WW'(r_in_col) == r_width - 1'b1);
    assign w_last_out_col = (WW'(r_out_col) == r_width - 1'b1);
    assign w_frame_end    = w_started && w_last_out_col && (r_out_row == r_height - 1'b1);

    always_comb begin
        n_in_col  = r_in_col;
        n_fill    = r_fill;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (w_geom_wr) begin
            n_in_col  = '0;
            n_fill    = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (w_s_acc) begin
            n_in_col = w_last_in_col ? '0 : r_in_col + 1'b1;
            if (!w_started) begin
                n_fill = r_fill + 1'b1;
            end else if (w_frame_end) begin
                n_in_col  = '0;
                n_fill    = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (w_last_out_col) begin
                n_out_col = '0;
                n_out_row = r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_fill    <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_fill    <= n_fill;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // zero padding: which window rows and columns fall inside the frame
    for (genvar go = 0; go < TAPS; go++) begin : g_mask
        localparam int OFF = go - RADIUS;
        logic signed [RSW-1:0] w_rr;
        logic signed [CW-1:0]  w_cc;
        assign w_rr = $signed({2'b00, r_out_row}) + RSW'(OFF);
        assign w_cc = $signed({2'b00, WW'(r_out_col)}) + CW'(OFF);
        assign w_row_ok[go] = !w_rr[RSW-1] && (w_rr < $signed({2'b00, r_height}));
        assign w_col_ok[go] = !w_cc[CW-1] && (w_cc < $signed({2'b00, r_width}));
    end

    // ---------------- pipeline control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_vld     <= {r_vld[PIPE_STAGES-2:0], w_s_acc};
            r_fwd_hit <= r_vld[0] && (r_in_col == r_a_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0]   <= '{has_res: w_started, frame_end: w_frame_end};
        for (int s = 1; s < PIPE_STAGES; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
        r_a_pix    <= w_pix;
        r_a_col    <= r_in_col;
        r_a_row_ok <= w_row_ok;
        r_a_col_ok <= w_col_ok;
        r_b_row_ok <= r_a_row_ok;
        r_b_col_ok <= r_a_col_ok;
        r_fwd_word <= w_wr_word;
    end

    // ---------------- line store ----------------
    // back-to-back words on one column: width of one, or first word after a frame end
    assign w_rd_word = r_fwd_hit ? r_fwd_word : w_ram_q;
    assign w_wr_word = {w_rd_word[LB_W-PIX_BUS_W-1:0], r_a_pix};

    wcv_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_vld[0]),
        .i_wr_addr (r_a_col),
        .i_wr_data (w_wr_word),
        .i_rd_en   (w_s_acc),
        .i_rd_addr (r_in_col),
        .o_rd_data (w_ram_q)
    );

    for (genvar gi = 0; gi < TAPS; gi++) begin : g_feed
        if (gi == TAPS - 1) begin : g_new
            assign w_row_feed[gi] = r_a_pix;
        end else begin : g_old
            assign w_row_feed[gi] = w_rd_word[(TAPS-2-gi)*PIX_BUS_W +: PIX_BUS_W];
        end
    end

    // ---------------- window cells ----------------
    for (genvar gi = 0; gi < TAPS; gi++) begin : g_row
        for (genvar gj = 0; gj < TAPS; gj++) begin : g_col
            logic [PIX_BUS_W-1:0]        w_feed;
            logic signed [COEF_BITS-1:0] w_coef;
            t_cell_ctl                   w_ctl;

            if (gj == TAPS - 1) begin : g_head
                assign w_feed = w_row_feed[gi];
            end else begin : g_link
                assign w_feed = w_win[gi][gj+1];
            end

            if (gj * COEF_BITS >= COEF_SPAN) begin : g_zero
                assign w_coef = '0;
            end else begin : g_sel
                assign w_coef = w_coef_ext[gi][gj*COEF_BITS +: COEF_BITS];
            end

            assign w_ctl = '{shift: r_vld[0], keep: r_b_row_ok[gi] & r_b_col_ok[gj]};

            wcv_cell #(
                .COEF_BITS (COEF_BITS)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_pix  (w_feed),
                .i_coef (w_coef),
                .o_pix  (w_win[gi][gj]),
                .o_prod (w_cell_prod[gi*TAPS+gj])
            );

            for (genvar gc = 0; gc < NUM_CH; gc++) begin : g_ch
                assign w_prod[gc][gi*TAPS+gj] = w_cell_prod[gi*TAPS+gj][gc];
            end
        end
    end

    for (genvar gc = 0; gc < NUM_CH; gc++) begin : g_sum
        wcv_sum #(
            .TAPS (TAPS),
            .PW   (PW)
        ) u_sum (
            .i_clk  (i_clk),
            .i_prod (w_prod[gc]),
            .o_sum  (w_sum[gc])
        );
    end

    // ---------------- output queue ----------------
    assign w_res.frame_end = r_tag[PIPE_STAGES-1].frame_end;
    assign w_res.sum0      = w_sum[0];
    assign w_res.sum1      = r_color ? w_sum[1] : '0;
    assign w_res.sum2      = r_color ? w_sum[2] : '0;

    assign w_push = r_vld[PIPE_STAGES-1] && r_tag[PIPE_STAGES-1].has_res;
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // room is reserved for every word still in the pipeline
    assign w_inflight    = INF_W'($countones(r_vld));
    assign w_occ         = OCC_W'(r_count) + OCC_W'(w_inflight);
    assign s_axis_tready = (w_occ < OCC_W'(FIFO_DEPTH));

    assign w_head        = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tlast  = w_head.frame_end;
    assign m_axis_tdata  = {{(OUT_DATA_W - NUM_CH*SUM_W){1'b0}},
                            w_head.sum2, w_head.sum1, w_head.sum0};

    // ---------------- assertions ----------------
    `WCV_ASSERT_ALWAYS(a_queue_room, i_clk, i_rst_n, w_occ <= OCC_W'(FIFO_DEPTH), "queue overrun")
    `WCV_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= w_lead, "fill count past lead")
    `WCV_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, w_s_acc && w_frame_end, r_fill == '0 && r_in_col == '0 && r_out_col == '0 && r_out_row == '0, "counters not restarted")
    `WCV_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, w_push && !w_pop, r_count < CNT_W'(FIFO_DEPTH), "push into full queue")

endmodule
